// ----- rtl/ax25_frame_header_encoder_defines.svh -----
// ----------------------------------------------------------------------------
// AX.25 frame header encoder assertion macros
// Clocked assertion macros shared by the encoder modules.
// ----------------------------------------------------------------------------
`ifndef AX25_FRAME_HEADER_ENCODER_DEFINES_SVH
`define AX25_FRAME_HEADER_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
`define AFHE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AFHE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define AFHE_ASSERT(lbl, clk, rst_n, prop, msg)
`define AFHE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/afhe_pkg.sv -----
// ----------------------------------------------------------------------------
// AX.25 frame header encoder package
// Shared types, request codes and control field constants.
// ----------------------------------------------------------------------------
package afhe_pkg;

	localparam int QueueDepthDefault = 4;
	localparam int MaxBytes = 7;
	localparam int IdxW = 3;

	localparam logic [1:0] OP_ADDRESS = 2'd0;
	localparam logic [1:0] OP_CONTROL = 2'd1;
	localparam logic [1:0] OP_PAYLOAD = 2'd2;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	localparam logic [2:0] KIND_SABM  = 3'd0;
	localparam logic [2:0] KIND_SABME = 3'd1;
	localparam logic [2:0] KIND_DISC  = 3'd2;
	localparam logic [2:0] KIND_DM    = 3'd3;
	localparam logic [2:0] KIND_UA    = 3'd4;
	localparam logic [2:0] KIND_RR    = 3'd5;
	localparam logic [2:0] KIND_REJ   = 3'd6;
	localparam logic [2:0] KIND_I     = 3'd7;

	localparam logic [7:0] CTL_SABM  = 8'b001_0_11_11;
	localparam logic [7:0] CTL_SABME = 8'b011_0_11_11;
	localparam logic [7:0] CTL_DISC  = 8'b010_0_00_11;
	localparam logic [7:0] CTL_DM    = 8'b000_0_11_11;
	localparam logic [7:0] CTL_UA    = 8'b011_0_00_11;
	localparam logic [7:0] CTL_RR    = 8'b000_0_00_01;
	localparam logic [7:0] CTL_REJ   = 8'b000_0_10_01;
	localparam logic [7:0] ASCII_SPACE = 8'h20;

	typedef struct packed {
		logic [MaxBytes-1:0][7:0] bytes;
		logic [IdxW-1:0]          last_idx;
		logic                     fend;
	} desc_t;

	typedef struct packed {
		logic  empty;
		desc_t head;
	} queue_stat_t;

endpackage

// ----- rtl/afhe_front.sv -----
// ----------------------------------------------------------------------------
// AX.25 encoder front end
// Accepts requests and turns each valid one into its list of frame bytes.
// ----------------------------------------------------------------------------
module afhe_front import afhe_pkg::*; (
	input  logic        start,
	input  logic        full,
	input  logic [1:0]  opcode,
	input  logic [47:0] callsign,
	input  logic [3:0]  ssid,
	input  logic        last_flag,
	input  logic        flag_c,
	input  logic        ext_flag,
	input  logic [2:0]  frame_kind,
	input  logic        poll,
	input  logic [6:0]  recv_seq,
	input  logic [6:0]  send_seq,
	input  logic [7:0]  byte_value,
	output logic        push,
	output desc_t       desc
);

	logic [7:0] ch;
	logic [7:0] pf;
	logic [7:0] nr8;
	logic [7:0] ns8;
	logic       valid_op;

	assign pf  = {3'b000, poll, 4'b0000};
	assign nr8 = {recv_seq[2:0], 5'b00000};
	assign ns8 = {4'b0000, send_seq[2:0], 1'b0};

	always_comb begin
		ch = '0;
		valid_op = 1'b1;
		desc = '0;
		unique case (opcode)
			OP_ADDRESS: begin
				for (int i = 0; i < 6; i++) begin
					ch = callsign[47-8*i -: 8];
					if (ch == 8'h00) begin
						ch = ASCII_SPACE;
					end
					desc.bytes[i] = {ch[6:0], 1'b0};
				end
				desc.bytes[6] = {flag_c, ~ext_flag, 1'b1, ssid, last_flag};
				desc.last_idx = IdxW'(6);
				desc.fend = 1'b0;
			end
			OP_CONTROL: begin
				desc.fend = 1'b1;
				unique case (frame_kind)
					KIND_SABM:  desc.bytes[0] = CTL_SABM | pf;
					KIND_SABME: desc.bytes[0] = CTL_SABME;
					KIND_DISC:  desc.bytes[0] = CTL_DISC | pf;
					KIND_DM:    desc.bytes[0] = CTL_DM;
					KIND_UA:    desc.bytes[0] = CTL_UA;
					KIND_RR, KIND_REJ: begin
						if (!ext_flag) begin
							desc.bytes[0] = ((frame_kind == KIND_RR) ? CTL_RR : CTL_REJ)
								| pf | nr8;
						end else begin
							desc.bytes[0] = (frame_kind == KIND_RR) ? CTL_RR : CTL_REJ;
							desc.bytes[1] = {recv_seq, poll};
							desc.last_idx = IdxW'(1);
						end
					end
					KIND_I: begin
						desc.fend = last_flag;
						if (!ext_flag) begin
							desc.bytes[0] = pf | nr8 | ns8;
							desc.bytes[1] = byte_value;
							desc.last_idx = IdxW'(1);
						end else begin
							desc.bytes[0] = {send_seq, 1'b0};
							desc.bytes[1] = {recv_seq, poll};
							desc.bytes[2] = byte_value;
							desc.last_idx = IdxW'(2);
						end
					end
					default: desc.bytes[0] = CTL_SABM;
				endcase
			end
			OP_PAYLOAD: begin
				desc.bytes[0] = byte_value;
				desc.fend = last_flag;
			end
			OP_UNUSED: valid_op = 1'b0;
			default:   valid_op = 1'b0;
		endcase
	end

	// An unused opcode is taken and dropped without reaching the queue.
	assign push = start && !full && valid_op;

endmodule

// ----- rtl/afhe_queue.sv -----
// ----------------------------------------------------------------------------
// AX.25 encoder request queue
// Short first-in first-out queue of byte lists between front and back end.
// ----------------------------------------------------------------------------
`include "ax25_frame_header_encoder_defines.svh"
module afhe_queue import afhe_pkg::*; #(
	parameter int Depth = QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  desc_t       wr_data,
	input  logic        pop,
	output logic        full,
	output queue_stat_t stat
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	desc_t           mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full = (count_q == CntW'(Depth));
	assign stat.empty = (count_q == '0);
	assign stat.head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	`AFHE_ASSERT_ALWAYS(a_count_bound, clk, count_q <= CntW'(Depth), "queue count above depth")
	`AFHE_ASSERT(a_no_overflow, clk, arst_n, push |-> !full, "push into a full queue")
	`AFHE_ASSERT(a_no_underflow, clk, arst_n, pop |-> !stat.empty, "pop from an empty queue")

endmodule

// ----- rtl/afhe_back.sv -----
// ----------------------------------------------------------------------------
// AX.25 encoder back end
// Sends the byte list at the head of the queue, one byte per cycle.
// ----------------------------------------------------------------------------
`include "ax25_frame_header_encoder_defines.svh"
module afhe_back import afhe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  queue_stat_t stat,
	output logic        pop,
	output logic        result_strobe,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        frame_end
);

	logic [IdxW-1:0] idx_q;
	logic            strobe_q;
	logic [7:0]      byte_q;
	logic            last_q;
	logic            fend_q;

	assign pop = !stat.empty && (idx_q == stat.head.last_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= !stat.empty;
			if (pop) begin
				idx_q <= '0;
			end else if (!stat.empty) begin
				idx_q <= idx_q + IdxW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= stat.head.bytes[idx_q];
		last_q <= pop;
		fend_q <= pop && stat.head.fend;
	end

	assign result_strobe = strobe_q;
	assign out_byte = byte_q;
	assign last_of_run = last_q;
	assign frame_end = fend_q;

	`AFHE_ASSERT(a_end_is_last, clk, arst_n, (strobe_q && fend_q) |-> last_q,
		"frame end on a byte that does not close its request")
	`AFHE_ASSERT(a_idx_bound, clk, arst_n, idx_q <= stat.head.last_idx || stat.empty,
		"byte index past the end of the head request")
	`AFHE_ASSERT(a_idx_held, clk, arst_n, (idx_q != '0) |-> !stat.empty,
		"head request left the queue mid-run")

endmodule

// ----- rtl/ax25_frame_header_encoder.sv -----
// ----------------------------------------------------------------------------
// AX.25 frame header encoder
// Turns address, control and payload requests into serialized frame bytes.
// ----------------------------------------------------------------------------
// Channel   Handshake               Payload
// request   start / busy            opcode ... byte_value
// result    result_strobe (1 cycle) out_byte, last_of_run, frame_end
//
// A request is taken in any cycle where busy is low; busy is high only while
// the request queue is full. While the queue holds a request, the back end sends
// one byte per cycle: a payload request sends 1 byte, a control request 1 to 3,
// an address request 7. When the queue is empty, a taken request is written
// into the queue and its first byte then passes through the output register.
// Results cannot be held off. Reset clears the queue and the byte counter.
// ----------------------------------------------------------------------------
module ax25_frame_header_encoder import afhe_pkg::*; #(
	parameter int QueueDepth = QueueDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [47:0] callsign,
	input  logic [3:0]  ssid,
	input  logic        last_flag,
	input  logic        flag_c,
	input  logic        ext_flag,
	input  logic [2:0]  frame_kind,
	input  logic        poll,
	input  logic [6:0]  recv_seq,
	input  logic [6:0]  send_seq,
	input  logic [7:0]  byte_value,
	output logic        result_strobe,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        frame_end
);

	logic        full;
	logic        push;
	logic        pop;
	desc_t       desc;
	queue_stat_t stat;

	assign busy = full;

	afhe_front u_front (
		.start      (start),
		.full       (full),
		.opcode     (opcode),
		.callsign   (callsign),
		.ssid       (ssid),
		.last_flag  (last_flag),
		.flag_c     (flag_c),
		.ext_flag   (ext_flag),
		.frame_kind (frame_kind),
		.poll       (poll),
		.recv_seq   (recv_seq),
		.send_seq   (send_seq),
		.byte_value (byte_value),
		.push       (push),
		.desc       (desc)
	);

	afhe_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (desc),
		.pop     (pop),
		.full    (full),
		.stat    (stat)
	);

	afhe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.stat          (stat),
		.pop           (pop),
		.result_strobe (result_strobe),
		.out_byte      (out_byte),
		.last_of_run   (last_of_run),
		.frame_end     (frame_end)
	);

endmodule
